@@ rtl/hef_pkg.sv @@
package hef_pkg;

   // table sizes and modifier groups
   localparam int MOD_GROUPS      = 8;
   localparam int MOD_ENTRIES     = 16;
   localparam int BINDING_ENTRIES = 16;

   localparam int MOD_IDX_W  = (MOD_ENTRIES > 1) ? $clog2(MOD_ENTRIES) : 1;
   localparam int BIND_IDX_W = (BINDING_ENTRIES > 1) ? $clog2(BINDING_ENTRIES) : 1;
   // wide enough for any table size and for the table index field
   localparam int IDX_EXT_W  = 7;
   // holds a group number or MOD_GROUPS itself
   localparam int BEST_W     = 4;

   localparam int KIND_W  = 2;
   localparam int TYPE_W  = 5;
   localparam int CODE_W  = 10;
   localparam int VALUE_W = 32;
   localparam int TIME_W  = 64;
   localparam int TIDX_W  = 4;
   localparam int GROUP_W = 3;
   localparam int MASK_W  = 8;

   localparam logic [KIND_W-1:0] KIND_EVENT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MOD   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BIND  = 2'd2;

   localparam logic [TYPE_W-1:0] TYPE_KEY   = 5'd1;
   localparam logic [TYPE_W-1:0] TYPE_MISC  = 5'd4;
   localparam logic [CODE_W-1:0] MISC_SCAN  = 10'd4;

   localparam logic signed [VALUE_W-1:0] VAL_RELEASE = 32'sd0;
   localparam logic signed [VALUE_W-1:0] VAL_PRESS   = 32'sd1;

   localparam logic OUT_FWD = 1'b0;
   localparam logic OUT_HOT = 1'b1;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [TYPE_W-1:0]         ev_type;
      logic [CODE_W-1:0]         ev_code;
      logic signed [VALUE_W-1:0] ev_value;
      logic [TIME_W-1:0]         ev_time;
      logic [TIDX_W-1:0]         table_index;
      logic [CODE_W-1:0]         table_key;
      logic [GROUP_W-1:0]        table_group;
      logic [MASK_W-1:0]         table_mask;
      logic                      table_valid;
   } hef_item_type;

   typedef struct packed {
      logic                      out_kind;
      logic [TYPE_W-1:0]         out_type;
      logic [CODE_W-1:0]         out_code;
      logic signed [VALUE_W-1:0] out_value;
      logic [TIME_W-1:0]         out_time;
      logic [TIDX_W-1:0]         hotkey_index;
      logic                      last;
   } hef_result_type;

   typedef struct packed {
      logic load_item;
      logic wr_mod;
      logic wr_bind;
      logic scan_clear;
      logic mod_step;
      logic apply;
      logic bind_step;
      logic load_hot;
      logic load_evt;
   } hef_cmd_type;

   typedef struct packed {
      logic kind_mod;
      logic kind_bind;
      logic evt_fwd;
      logic key_act;
      logic mod_last;
      logic bind_last;
      logic need_bind;
      logic found;
      logic release_ev;
   } hef_status_type;

endpackage

@@ rtl/hef_if.sv @@
interface hef_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [hef_pkg::KIND_W-1:0]             kind;
   logic [hef_pkg::TYPE_W-1:0]             ev_type;
   logic [hef_pkg::CODE_W-1:0]             ev_code;
   logic signed [hef_pkg::VALUE_W-1:0]     ev_value;
   logic [hef_pkg::TIME_W-1:0]             ev_time;
   logic [hef_pkg::TIDX_W-1:0]             table_index;
   logic [hef_pkg::CODE_W-1:0]             table_key;
   logic [hef_pkg::GROUP_W-1:0]            table_group;
   logic [hef_pkg::MASK_W-1:0]             table_mask;
   logic                                   table_valid;

   modport source (
      output valid, kind, ev_type, ev_code, ev_value, ev_time,
             table_index, table_key, table_group, table_mask, table_valid,
      input  ready
   );
   modport sink (
      input  valid, kind, ev_type, ev_code, ev_value, ev_time,
             table_index, table_key, table_group, table_mask, table_valid,
      output ready
   );
endinterface

interface hef_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   out_kind;
   logic [hef_pkg::TYPE_W-1:0]             out_type;
   logic [hef_pkg::CODE_W-1:0]             out_code;
   logic signed [hef_pkg::VALUE_W-1:0]     out_value;
   logic [hef_pkg::TIME_W-1:0]             out_time;
   logic [hef_pkg::TIDX_W-1:0]             hotkey_index;
   logic                                   last;

   modport source (
      output valid, out_kind, out_type, out_code, out_value, out_time,
             hotkey_index, last,
      input  ready
   );
   modport sink (
      input  valid, out_kind, out_type, out_code, out_value, out_time,
             hotkey_index, last,
      output ready
   );
endinterface

@@ rtl/hotkey_event_filter_unit.sv @@
// a table write is stored on accept; forwarded non-key events pass S_DECIDE and S_SEND_EVT
// key press/release: modifier scan, apply, binding scan if needed, then decide and send
// one item at a time, taken only in S_IDLE; the two tables are scanned one entry per cycle;
// a table write can be taken every cycle, since it leaves the unit in S_IDLE
// a release that fires a hotkey gives two beats, hotkey first
// reset (synchronous): modifier mask and last key cleared, all table entries invalid
module hotkey_event_filter_unit (
   input  logic      clock,
   input  logic      reset,
   hef_req_if.sink   req_ch,
   hef_rsp_if.source rsp_ch
);

   hef_pkg::hef_cmd_type    cmd;
   hef_pkg::hef_status_type st;
   hef_pkg::hef_item_type   req_item;
   hef_pkg::hef_result_type rsp_item;

   always_comb begin
      req_item.kind        = req_ch.kind;
      req_item.ev_type     = req_ch.ev_type;
      req_item.ev_code     = req_ch.ev_code;
      req_item.ev_value    = req_ch.ev_value;
      req_item.ev_time     = req_ch.ev_time;
      req_item.table_index = req_ch.table_index;
      req_item.table_key   = req_ch.table_key;
      req_item.table_group = req_ch.table_group;
      req_item.table_mask  = req_ch.table_mask;
      req_item.table_valid = req_ch.table_valid;
   end

   assign rsp_ch.out_kind     = rsp_item.out_kind;
   assign rsp_ch.out_type     = rsp_item.out_type;
   assign rsp_ch.out_code     = rsp_item.out_code;
   assign rsp_ch.out_value    = rsp_item.out_value;
   assign rsp_ch.out_time     = rsp_item.out_time;
   assign rsp_ch.hotkey_index = rsp_item.hotkey_index;
   assign rsp_ch.last         = rsp_item.last;

   hef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   hef_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .st       (st),
      .rsp_item (rsp_item)
   );

endmodule

@@ rtl/hef_dpath.sv @@
module hef_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  hef_pkg::hef_cmd_type    cmd,
   input  hef_pkg::hef_item_type   req_item,
   output hef_pkg::hef_status_type st,
   output hef_pkg::hef_result_type rsp_item
);

   hef_pkg::hef_item_type   item_ff;
   hef_pkg::hef_result_type rsp_ff;

   logic [hef_pkg::MOD_ENTRIES-1:0]     mod_valid_ff;
   logic [hef_pkg::CODE_W-1:0]          mod_key_ff [hef_pkg::MOD_ENTRIES];
   logic [hef_pkg::GROUP_W-1:0]         mod_group_ff [hef_pkg::MOD_ENTRIES];
   logic [hef_pkg::BINDING_ENTRIES-1:0] bind_valid_ff;
   logic [hef_pkg::CODE_W-1:0]          bind_key_ff [hef_pkg::BINDING_ENTRIES];
   logic [hef_pkg::MASK_W-1:0]          bind_mask_ff [hef_pkg::BINDING_ENTRIES];

   logic [hef_pkg::MOD_IDX_W-1:0]  mod_idx_ff;
   logic [hef_pkg::BIND_IDX_W-1:0] bind_idx_ff;
   logic [hef_pkg::BEST_W-1:0]     best_ff;
   logic                           found_ff;
   logic [hef_pkg::BIND_IDX_W-1:0] hit_ff;
   logic [hef_pkg::MASK_W-1:0]     mod_state_ff;
   logic [hef_pkg::CODE_W-1:0]     last_key_ff;

   logic [hef_pkg::IDX_EXT_W-1:0]  wr_idx;
   logic                           wr_mod_ok;
   logic                           wr_bind_ok;
   logic [hef_pkg::BEST_W-1:0]     grp_ext;
   logic                           mod_hit;
   logic                           bind_hit;
   logic [hef_pkg::BEST_W-1:0]     shift_amt;
   logic [hef_pkg::MASK_W-1:0]     key_mask;
   logic                           is_release;
   logic [hef_pkg::IDX_EXT_W-1:0]  hit_ext;

   assign wr_idx     = hef_pkg::IDX_EXT_W'(req_item.table_index);
   assign wr_mod_ok  = wr_idx < hef_pkg::IDX_EXT_W'(hef_pkg::MOD_ENTRIES);
   assign wr_bind_ok = wr_idx < hef_pkg::IDX_EXT_W'(hef_pkg::BINDING_ENTRIES);

   // lowest valid group of a matching entry wins
   assign grp_ext = hef_pkg::BEST_W'(mod_group_ff[mod_idx_ff]);
   assign mod_hit = mod_valid_ff[mod_idx_ff] && (mod_key_ff[mod_idx_ff] == item_ff.ev_code)
                    && (grp_ext < hef_pkg::BEST_W'(hef_pkg::MOD_GROUPS)) && (grp_ext < best_ff);

   assign bind_hit = bind_valid_ff[bind_idx_ff] && (bind_key_ff[bind_idx_ff] == item_ff.ev_code)
                     && (bind_mask_ff[bind_idx_ff] == mod_state_ff);

   // group g maps to mask bit MOD_GROUPS-1-g
   assign shift_amt = hef_pkg::BEST_W'(hef_pkg::MOD_GROUPS - 1) - best_ff;
   assign key_mask  = (best_ff < hef_pkg::BEST_W'(hef_pkg::MOD_GROUPS)) ?
                      (hef_pkg::MASK_W'(1) << shift_amt) : '0;

   assign is_release = item_ff.ev_value == hef_pkg::VAL_RELEASE;
   assign hit_ext    = hef_pkg::IDX_EXT_W'(hit_ff);

   always_comb begin
      st.kind_mod   = req_item.kind == hef_pkg::KIND_MOD;
      st.kind_bind  = req_item.kind == hef_pkg::KIND_BIND;
      st.evt_fwd    = (req_item.kind == hef_pkg::KIND_EVENT)
                      && (req_item.ev_type != hef_pkg::TYPE_KEY)
                      && !((req_item.ev_type == hef_pkg::TYPE_MISC)
                           && (req_item.ev_code == hef_pkg::MISC_SCAN));
      st.key_act    = (req_item.kind == hef_pkg::KIND_EVENT)
                      && (req_item.ev_type == hef_pkg::TYPE_KEY)
                      && ((req_item.ev_value == hef_pkg::VAL_PRESS)
                          || (req_item.ev_value == hef_pkg::VAL_RELEASE));
      st.mod_last   = mod_idx_ff == hef_pkg::MOD_IDX_W'(hef_pkg::MOD_ENTRIES - 1);
      st.bind_last  = bind_idx_ff == hef_pkg::BIND_IDX_W'(hef_pkg::BINDING_ENTRIES - 1);
      st.need_bind  = is_release ? ((key_mask != '0) && (last_key_ff == item_ff.ev_code))
                                 : (key_mask == '0);
      st.found      = found_ff;
      st.release_ev = is_release;
   end

   assign rsp_item = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_valid_ff  <= '0;
         bind_valid_ff <= '0;
         mod_state_ff  <= '0;
         last_key_ff   <= '0;
         mod_idx_ff    <= '0;
         bind_idx_ff   <= '0;
         best_ff       <= hef_pkg::BEST_W'(hef_pkg::MOD_GROUPS);
         found_ff      <= 1'b0;
      end else begin
         if (cmd.wr_mod && wr_mod_ok) begin
            mod_valid_ff[wr_idx[hef_pkg::MOD_IDX_W-1:0]] <= req_item.table_valid;
         end
         if (cmd.wr_bind && wr_bind_ok) begin
            bind_valid_ff[wr_idx[hef_pkg::BIND_IDX_W-1:0]] <= req_item.table_valid;
         end
         if (cmd.scan_clear) begin
            mod_idx_ff  <= '0;
            bind_idx_ff <= '0;
            best_ff     <= hef_pkg::BEST_W'(hef_pkg::MOD_GROUPS);
            found_ff    <= 1'b0;
         end
         if (cmd.mod_step) begin
            mod_idx_ff <= mod_idx_ff + 1'b1;
            if (mod_hit) begin
               best_ff <= grp_ext;
            end
         end
         if (cmd.apply) begin
            if (is_release) begin
               mod_state_ff <= mod_state_ff ^ key_mask;
            end else begin
               mod_state_ff <= mod_state_ff | key_mask;
               last_key_ff  <= item_ff.ev_code;
            end
         end
         if (cmd.bind_step) begin
            bind_idx_ff <= bind_idx_ff + 1'b1;
            if (bind_hit && !found_ff) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_item;
      end
      if (cmd.wr_mod && wr_mod_ok) begin
         mod_key_ff[wr_idx[hef_pkg::MOD_IDX_W-1:0]]   <= req_item.table_key;
         mod_group_ff[wr_idx[hef_pkg::MOD_IDX_W-1:0]] <= req_item.table_group;
      end
      if (cmd.wr_bind && wr_bind_ok) begin
         bind_key_ff[wr_idx[hef_pkg::BIND_IDX_W-1:0]]  <= req_item.table_key;
         bind_mask_ff[wr_idx[hef_pkg::BIND_IDX_W-1:0]] <= req_item.table_mask;
      end
      if (cmd.bind_step && bind_hit && !found_ff) begin
         hit_ff <= bind_idx_ff;
      end
      if (cmd.load_hot) begin
         rsp_ff.out_kind     <= hef_pkg::OUT_HOT;
         rsp_ff.out_type     <= '0;
         rsp_ff.out_code     <= '0;
         rsp_ff.out_value    <= '0;
         rsp_ff.out_time     <= '0;
         rsp_ff.hotkey_index <= hit_ext[hef_pkg::TIDX_W-1:0];
         // a release still owes its forwarded event
         rsp_ff.last         <= !is_release;
      end else if (cmd.load_evt) begin
         rsp_ff.out_kind     <= hef_pkg::OUT_FWD;
         rsp_ff.out_type     <= item_ff.ev_type;
         rsp_ff.out_code     <= item_ff.ev_code;
         rsp_ff.out_value    <= item_ff.ev_value;
         rsp_ff.out_time     <= item_ff.ev_time;
         rsp_ff.hotkey_index <= '0;
         rsp_ff.last         <= 1'b1;
      end
   end

endmodule

@@ rtl/hef_ctrl.sv @@
module hef_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  hef_pkg::hef_status_type st,
   output hef_pkg::hef_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD_SCAN,
      S_APPLY,
      S_BIND_SCAN,
      S_DECIDE,
      S_SEND_HOT,
      S_SEND_EVT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = ((state_ff == S_SEND_HOT) || (state_ff == S_SEND_EVT)) && !reset;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_item  = 1'b1;
               cmd.scan_clear = 1'b1;
               cmd.wr_mod     = st.kind_mod;
               cmd.wr_bind    = st.kind_bind;
               if (st.evt_fwd) begin
                  state_in = S_DECIDE;
               end else if (st.key_act) begin
                  state_in = S_MOD_SCAN;
               end
            end
         end
         S_MOD_SCAN: begin
            cmd.mod_step = 1'b1;
            if (st.mod_last) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = st.need_bind ? S_BIND_SCAN : S_DECIDE;
         end
         S_BIND_SCAN: begin
            cmd.bind_step = 1'b1;
            if (st.bind_last) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (st.found) begin
               cmd.load_hot = 1'b1;
               state_in     = S_SEND_HOT;
            end else begin
               cmd.load_evt = 1'b1;
               state_in     = S_SEND_EVT;
            end
         end
         S_SEND_HOT: begin
            if (rsp_ready) begin
               if (st.release_ev) begin
                  cmd.load_evt = 1'b1;
                  state_in     = S_SEND_EVT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SEND_EVT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
